@@ design/kts_pkg.sv @@
// ----------------------------------------------------------------------------
// kts_pkg: shared constants and helpers for the keyframe transform sampler
// Field layout, table sizes, fixed-point constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
package kts_pkg;

    localparam int MAX_KEYS     = 64;
    localparam int NUM_TRACKS   = 3;
    localparam int KEY_ADDR_W   = $clog2(NUM_TRACKS * MAX_KEYS);
    localparam int KEY_CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_GAIN  = 39797;
    localparam int QONE         = 65536;

    localparam int S_TDATA_W  = 168;
    localparam int S_TUSER_W  = 4;
    localparam int M_TDATA_W  = 136;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] OP_LOAD_KEY  = 2'd0;
    localparam logic [1:0] OP_LOAD_REST = 2'd1;
    localparam logic [1:0] OP_SAMPLE    = 2'd2;

    localparam logic [1:0] TRK_ROT = 2'd0;
    localparam logic [1:0] TRK_POS = 2'd1;
    localparam logic [1:0] TRK_SCL = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_DURATION = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_CNT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_POS_CNT  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SCL_CNT  = 2'd3;

    function automatic logic [15:0] atan_step(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30386;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ design/keyframe_transform_sampler_top.sv @@
// ----------------------------------------------------------------------------
// keyframe_transform_sampler_top: keyframe pose sampler
// Input words load keys and the rest pose or request a sample. A sample word
// gives a time; the block finds the bracketing keys of the rotation, position
// and scale tracks, interpolates them (slerp for rotation, lerp otherwise) and
// sends the three rows of [R*diag(s) | p] as three output words, the last one
// marked by m_tlast. With a clip duration of zero or less the rest pose is sent.
// Load words keep s_tready high. A sample holds s_tready low until its last
// row is in the output register, a time set by the one-key-per-cycle scan of
// the key memory, the 52-step restoring divider shared by the four slerp
// components and the 16-step CORDIC passes, all skipped for the rest pose.
// One multiplier serves all products. Each row sits in an output register
// until m_tready takes it; a stalled receiver stalls the sequencer at the
// next row. Reset (aresetn low, sync) clears the state, config and output
// flag registers and sets the rest pose to identity; the key memory is not
// cleared, keys must be loaded before they are counted as valid.
// ----------------------------------------------------------------------------
module keyframe_transform_sampler_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // key_index, time_value, comp_a, comp_b, comp_c, comp_d, zero pad
    input  logic [kts_pkg::S_TDATA_W-1:0]    s_tdata,
    // op, track
    input  logic [kts_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // row_index, col0, col1, col2, col3, zero pad
    output logic [kts_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [kts_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [kts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import kts_pkg::*;

    localparam int CW = 20;
    localparam int ZW = 21;

    typedef enum logic [4:0] {
        S_IDLE, S_TRK_INIT, S_SCAN, S_SPAN, S_DIV, S_FSEL, S_LERP, S_DOT, S_DSIGN,
        S_DSQ, S_SQI, S_SQRT, S_ANG, S_WM, S_SINI, S_SIN, S_NA, S_NB, S_NS,
        S_DIVI, S_QFIN, S_TRK_DONE, S_MQ, S_MS, S_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic signed [31:0]   dur_reg;
    logic [6:0]           cnt_reg [3];

    // key memory: time, comp_a..comp_d
    logic [159:0]         key_mem [NUM_TRACKS*MAX_KEYS];
    logic [159:0]         key_rd_q;
    logic                 key_we;
    logic [KEY_ADDR_W-1:0] key_waddr;
    logic                 rd_en;
    logic [KEY_ADDR_W-1:0] rd_addr;

    logic signed [31:0]   rest_reg [3][4];
    logic signed [31:0]   trk_res_reg [3][4];

    // per-track working registers
    logic signed [31:0]   t_reg;
    logic [1:0]           track_reg;
    logic [KEY_CNT_W-1:0] idx_reg;
    logic [KEY_CNT_W-1:0] lim_reg;
    logic                 pend_reg;
    logic                 found_reg;
    logic signed [31:0]   t1_reg;
    logic signed [31:0]   t2_reg;
    logic signed [31:0]   a_reg [4];
    logic signed [32:0]   b_reg [4];
    logic [16:0]          f_reg;
    logic [5:0]           k_reg;
    logic [1:0]           j_reg;

    // shared multiplier
    logic signed [33:0]   mul_a;
    logic signed [33:0]   mul_b;
    logic signed [67:0]   prod_reg;

    // shared divider
    logic [32:0]          rem_reg;
    logic [51:0]          dq_reg;
    logic [31:0]          den_reg;
    logic [5:0]           div_n_reg;
    logic                 div_f_reg;
    logic                 neg_reg;
    logic signed [51:0]   num_reg;

    // slerp
    logic signed [49:0]   d_reg;
    logic [32:0]          v_reg;
    logic [33:0]          r_reg;
    logic [32:0]          bit_reg;
    logic signed [CW-1:0] cx_reg;
    logic signed [CW-1:0] cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic signed [ZW-1:0] th_reg;
    logic                 phase_reg;
    logic signed [CW-1:0] w1_reg;
    logic signed [CW-1:0] w2_reg;

    // matrix
    logic signed [47:0]   qp_reg [9];
    logic signed [31:0]   rot_reg;
    logic signed [31:0]   col_reg [3];
    logic [1:0]           row_reg;

    logic                 m_tvalid_reg;
    logic                 m_tlast_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // input fields
    logic [1:0]           in_op;
    logic [1:0]           in_track;
    logic [5:0]           in_key;
    logic signed [31:0]   in_time;
    logic signed [31:0]   in_comp [4];
    logic                 s_accept;

    assign in_op      = s_tuser[1:0];
    assign in_track   = s_tuser[3:2];
    assign in_key     = s_tdata[5:0];
    assign in_time    = s_tdata[37:6];
    assign in_comp[0] = s_tdata[69:38];
    assign in_comp[1] = s_tdata[101:70];
    assign in_comp[2] = s_tdata[133:102];
    assign in_comp[3] = s_tdata[165:134];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------------------------------------------------------- memory
    assign key_we = s_accept && (in_op == OP_LOAD_KEY) && (in_track != 2'd3) &&
                    (32'(in_key) < MAX_KEYS);
    assign key_waddr = KEY_ADDR_W'(in_track) * KEY_ADDR_W'(MAX_KEYS) + KEY_ADDR_W'(in_key);
    assign rd_en   = (state_reg == S_SCAN) && (idx_reg < lim_reg);
    assign rd_addr = KEY_ADDR_W'(track_reg) * KEY_ADDR_W'(MAX_KEYS) + KEY_ADDR_W'(idx_reg);

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= s_tdata[165:6];
        end
        if (rd_en) begin
            key_rd_q <= key_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------- helpers
    logic signed [31:0]   kt;
    logic                 hit_start;
    logic                 hit_end;
    logic [6:0]           cnt_sel;
    logic [KEY_CNT_W-1:0] cnt_eff;
    logic signed [32:0]   span;
    logic signed [32:0]   diff;
    logic [5:0]           km1;
    logic [5:0]           km2;
    logic [32:0]          rem_sh;
    logic [33:0]          rem_diff;
    logic                 div_take;
    logic [34:0]          sq_trial;
    logic                 sq_take;
    logic signed [CW-1:0] cx_sh;
    logic signed [CW-1:0] cy_sh;
    logic signed [ZW-1:0] atan_k;
    logic signed [49:0]   d_abs;
    logic signed [35:0]   lerp_sum;
    logic signed [52:0]   quo_s;
    logic signed [51:0]   rot_full;
    logic signed [51:0]   qxx, qyy, qzz, qxy, qxz, qyz, qwx, qwy, qwz;

    assign kt        = key_rd_q[31:0];
    assign hit_start = (t_reg >= kt) && (found_reg ? (kt > t1_reg) : (kt >= t1_reg));
    assign hit_end   = (kt > t_reg) && (kt <= t2_reg);
    assign cnt_sel   = cnt_reg[track_reg];
    assign cnt_eff   = (32'(cnt_sel) > MAX_KEYS) ? KEY_CNT_W'(MAX_KEYS) : KEY_CNT_W'(cnt_sel);
    assign span      = 33'(t2_reg) - 33'(t1_reg);
    assign diff      = 33'(t_reg) - 33'(t1_reg);
    assign km1       = k_reg - 6'd1;
    assign km2       = k_reg - 6'd2;

    assign rem_sh    = {rem_reg[31:0], dq_reg[51]};
    assign rem_diff  = {1'b0, rem_sh} - {2'b00, den_reg};
    assign div_take  = !rem_diff[33];

    assign sq_trial  = 35'(r_reg) + 35'(bit_reg);
    assign sq_take   = (35'(v_reg) >= sq_trial);

    assign cx_sh     = cx_reg >>> k_reg[3:0];
    assign cy_sh     = cy_reg >>> k_reg[3:0];
    assign atan_k    = ZW'(atan_step(k_reg[3:0]));

    assign d_abs     = d_reg[49] ? -d_reg : d_reg;
    assign lerp_sum  = 36'(a_reg[km1[1:0]]) + 36'(prod_reg >>> 16);
    assign quo_s     = neg_reg ? -53'({1'b0, dq_reg}) : 53'({1'b0, dq_reg});

    assign qxx = 52'(qp_reg[0]);
    assign qyy = 52'(qp_reg[1]);
    assign qzz = 52'(qp_reg[2]);
    assign qxy = 52'(qp_reg[3]);
    assign qxz = 52'(qp_reg[4]);
    assign qyz = 52'(qp_reg[5]);
    assign qwx = 52'(qp_reg[6]);
    assign qwy = 52'(qp_reg[7]);
    assign qwz = 52'(qp_reg[8]);

    always_comb begin
        case ({row_reg, k_reg[1:0]})
            4'b00_00: rot_full = 52'(QONE) - 2 * (qyy + qzz);
            4'b00_01: rot_full = 2 * (qxy - qwz);
            4'b00_10: rot_full = 2 * (qxz + qwy);
            4'b01_00: rot_full = 2 * (qxy + qwz);
            4'b01_01: rot_full = 52'(QONE) - 2 * (qxx + qzz);
            4'b01_10: rot_full = 2 * (qyz - qwx);
            4'b10_00: rot_full = 2 * (qxz - qwy);
            4'b10_01: rot_full = 2 * (qyz + qwx);
            4'b10_10: rot_full = 52'(QONE) - 2 * (qxx + qyy);
            default:  rot_full = '0;
        endcase
    end

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_DOT: begin
                mul_a = 34'(a_reg[k_reg[1:0]]);
                mul_b = 34'(b_reg[k_reg[1:0]]);
            end
            S_LERP: begin
                mul_a = 34'(b_reg[k_reg[1:0]]) - 34'(a_reg[k_reg[1:0]]);
                mul_b = 34'(f_reg);
            end
            S_DSQ: begin
                mul_a = 34'(d_reg);
                mul_b = 34'(d_reg);
            end
            S_WM: begin
                mul_a = phase_reg ? 34'(f_reg) : 34'(QONE) - 34'(f_reg);
                mul_b = 34'(th_reg);
            end
            S_NA: begin
                mul_a = 34'(w1_reg);
                mul_b = 34'(a_reg[j_reg]);
            end
            S_NB: begin
                mul_a = 34'(w2_reg);
                mul_b = 34'(b_reg[j_reg]);
            end
            S_MQ: begin
                // w x y z = comp 0..3
                case (k_reg[3:0])
                    4'd0: begin mul_a = 34'(trk_res_reg[0][1]); mul_b = 34'(trk_res_reg[0][1]); end
                    4'd1: begin mul_a = 34'(trk_res_reg[0][2]); mul_b = 34'(trk_res_reg[0][2]); end
                    4'd2: begin mul_a = 34'(trk_res_reg[0][3]); mul_b = 34'(trk_res_reg[0][3]); end
                    4'd3: begin mul_a = 34'(trk_res_reg[0][1]); mul_b = 34'(trk_res_reg[0][2]); end
                    4'd4: begin mul_a = 34'(trk_res_reg[0][1]); mul_b = 34'(trk_res_reg[0][3]); end
                    4'd5: begin mul_a = 34'(trk_res_reg[0][2]); mul_b = 34'(trk_res_reg[0][3]); end
                    4'd6: begin mul_a = 34'(trk_res_reg[0][0]); mul_b = 34'(trk_res_reg[0][1]); end
                    4'd7: begin mul_a = 34'(trk_res_reg[0][0]); mul_b = 34'(trk_res_reg[0][2]); end
                    4'd8: begin mul_a = 34'(trk_res_reg[0][0]); mul_b = 34'(trk_res_reg[0][3]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_MS: begin
                mul_a = 34'(rot_reg);
                mul_b = 34'(trk_res_reg[2][km1[1:0]]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            dur_reg      <= '0;
            for (int i = 0; i < 3; i++) begin
                cnt_reg[i] <= '0;
                for (int c = 0; c < 4; c++) begin
                    rest_reg[i][c] <= '0;
                end
            end
            rest_reg[0][0] <= 32'(QONE);
            rest_reg[2][0] <= 32'(QONE);
            rest_reg[2][1] <= 32'(QONE);
            rest_reg[2][2] <= 32'(QONE);
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_DURATION: dur_reg    <= cfg_wdata;
                    REG_ROT_CNT:  cnt_reg[0] <= cfg_wdata[6:0];
                    REG_POS_CNT:  cnt_reg[1] <= cfg_wdata[6:0];
                    REG_SCL_CNT:  cnt_reg[2] <= cfg_wdata[6:0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (in_op == OP_LOAD_REST && in_track != 2'd3) begin
                            for (int c = 0; c < 4; c++) begin
                                rest_reg[in_track][c] <= in_comp[c];
                            end
                        end else if (in_op == OP_SAMPLE) begin
                            t_reg <= in_time;
                            if (dur_reg <= 32'sd0) begin
                                trk_res_reg <= rest_reg;
                                row_reg     <= '0;
                                k_reg       <= '0;
                                state_reg   <= S_MQ;
                            end else begin
                                track_reg <= TRK_ROT;
                                state_reg <= S_TRK_INIT;
                            end
                        end
                    end
                end
                S_TRK_INIT: begin
                    for (int c = 0; c < 4; c++) begin
                        a_reg[c] <= rest_reg[track_reg][c];
                        b_reg[c] <= 33'(rest_reg[track_reg][c]);
                    end
                    t1_reg    <= '0;
                    t2_reg    <= dur_reg;
                    found_reg <= 1'b0;
                    idx_reg   <= '0;
                    pend_reg  <= 1'b0;
                    lim_reg   <= cnt_eff;
                    state_reg <= S_SCAN;
                end
                S_SCAN: begin
                    // one key per cycle: start key and end key tracked together
                    pend_reg <= rd_en;
                    if (rd_en) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (pend_reg) begin
                        if (hit_start) begin
                            t1_reg    <= kt;
                            found_reg <= 1'b1;
                            for (int c = 0; c < 4; c++) begin
                                a_reg[c] <= key_rd_q[32*c+32 +: 32];
                            end
                        end
                        if (hit_end) begin
                            t2_reg <= kt;
                            for (int c = 0; c < 4; c++) begin
                                b_reg[c] <= 33'($signed(key_rd_q[32*c+32 +: 32]));
                            end
                        end
                    end
                    if (!rd_en && !pend_reg) begin
                        state_reg <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    if (span <= 33'sd0) begin
                        for (int c = 0; c < 4; c++) begin
                            trk_res_reg[track_reg][c] <= a_reg[c];
                        end
                        state_reg <= S_TRK_DONE;
                    end else if (diff < 33'sd0) begin
                        f_reg     <= '0;
                        state_reg <= S_FSEL;
                    end else if (diff >= span) begin
                        f_reg     <= 17'(QONE);
                        state_reg <= S_FSEL;
                    end else begin
                        // remainder starts below the divisor: 16 quotient bits
                        rem_reg   <= 33'(diff);
                        dq_reg    <= '0;
                        den_reg   <= span[31:0];
                        div_n_reg <= 6'd16;
                        div_f_reg <= 1'b1;
                        k_reg     <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (k_reg == div_n_reg) begin
                        if (div_f_reg) begin
                            f_reg     <= dq_reg[16:0];
                            state_reg <= S_FSEL;
                        end else begin
                            state_reg <= S_QFIN;
                        end
                    end else begin
                        rem_reg <= div_take ? rem_diff[32:0] : rem_sh;
                        dq_reg  <= {dq_reg[50:0], div_take};
                        k_reg   <= k_reg + 6'd1;
                    end
                end
                S_FSEL: begin
                    k_reg     <= '0;
                    d_reg     <= '0;
                    state_reg <= (track_reg == TRK_ROT) ? S_DOT : S_LERP;
                end
                S_LERP: begin
                    if (k_reg != 6'd0) begin
                        trk_res_reg[track_reg][km1[1:0]] <= sat32(68'(lerp_sum));
                    end
                    k_reg <= k_reg + 6'd1;
                    if (k_reg == 6'd4) begin
                        state_reg <= S_TRK_DONE;
                    end
                end
                S_DOT: begin
                    if (k_reg != 6'd0) begin
                        d_reg <= d_reg + 50'(prod_reg >>> 16);
                    end
                    k_reg <= k_reg + 6'd1;
                    if (k_reg == 6'd4) begin
                        state_reg <= S_DSIGN;
                    end
                end
                S_DSIGN: begin
                    d_reg <= d_abs;
                    if (d_reg[49]) begin
                        for (int c = 0; c < 4; c++) begin
                            b_reg[c] <= -b_reg[c];
                        end
                    end
                    k_reg     <= '0;
                    state_reg <= (d_abs >= 50'(QONE)) ? S_LERP : S_DSQ;
                end
                S_DSQ: begin
                    state_reg <= S_SQI;
                end
                S_SQI: begin
                    v_reg     <= 33'h1_0000_0000 - prod_reg[32:0];
                    r_reg     <= '0;
                    bit_reg   <= 33'h1_0000_0000;
                    state_reg <= S_SQRT;
                end
                S_SQRT: begin
                    if (bit_reg == '0) begin
                        den_reg   <= 32'(r_reg);
                        cx_reg    <= CW'(d_reg);
                        cy_reg    <= CW'(r_reg);
                        cz_reg    <= '0;
                        k_reg     <= '0;
                        state_reg <= S_ANG;
                    end else begin
                        if (sq_take) begin
                            v_reg <= v_reg - sq_trial[32:0];
                            r_reg <= (r_reg >> 1) + 34'(bit_reg);
                        end else begin
                            r_reg <= r_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_ANG: begin
                    if (k_reg == 6'(CORDIC_STEPS)) begin
                        th_reg    <= cz_reg;
                        phase_reg <= 1'b0;
                        state_reg <= S_WM;
                    end else begin
                        if (!cy_reg[CW-1]) begin
                            cx_reg <= cx_reg + cy_sh;
                            cy_reg <= cy_reg - cx_sh;
                            cz_reg <= cz_reg + atan_k;
                        end else begin
                            cx_reg <= cx_reg - cy_sh;
                            cy_reg <= cy_reg + cx_sh;
                            cz_reg <= cz_reg - atan_k;
                        end
                        k_reg <= k_reg + 6'd1;
                    end
                end
                S_WM: begin
                    state_reg <= S_SINI;
                end
                S_SINI: begin
                    cz_reg    <= ZW'(prod_reg >>> 16);
                    cx_reg    <= CW'(CORDIC_GAIN);
                    cy_reg    <= '0;
                    k_reg     <= '0;
                    state_reg <= S_SIN;
                end
                S_SIN: begin
                    if (k_reg == 6'(CORDIC_STEPS)) begin
                        if (!phase_reg) begin
                            w1_reg    <= cy_reg;
                            phase_reg <= 1'b1;
                            state_reg <= S_WM;
                        end else begin
                            w2_reg    <= cy_reg;
                            j_reg     <= '0;
                            state_reg <= S_NA;
                        end
                    end else begin
                        if (!cz_reg[ZW-1]) begin
                            cx_reg <= cx_reg - cy_sh;
                            cy_reg <= cy_reg + cx_sh;
                            cz_reg <= cz_reg - atan_k;
                        end else begin
                            cx_reg <= cx_reg + cy_sh;
                            cy_reg <= cy_reg - cx_sh;
                            cz_reg <= cz_reg + atan_k;
                        end
                        k_reg <= k_reg + 6'd1;
                    end
                end
                S_NA: begin
                    state_reg <= S_NB;
                end
                S_NB: begin
                    num_reg   <= 52'(prod_reg);
                    state_reg <= S_NS;
                end
                S_NS: begin
                    num_reg   <= num_reg + 52'(prod_reg);
                    state_reg <= S_DIVI;
                end
                S_DIVI: begin
                    neg_reg   <= num_reg[51];
                    dq_reg    <= num_reg[51] ? 52'(-num_reg) : 52'(num_reg);
                    rem_reg   <= '0;
                    div_n_reg <= 6'd52;
                    div_f_reg <= 1'b0;
                    k_reg     <= '0;
                    state_reg <= S_DIV;
                end
                S_QFIN: begin
                    trk_res_reg[TRK_ROT][j_reg] <= sat32(68'(quo_s));
                    j_reg <= j_reg + 2'd1;
                    state_reg <= (j_reg == 2'd3) ? S_TRK_DONE : S_NA;
                end
                S_TRK_DONE: begin
                    if (track_reg == TRK_SCL) begin
                        row_reg   <= '0;
                        k_reg     <= '0;
                        state_reg <= S_MQ;
                    end else begin
                        track_reg <= track_reg + 2'd1;
                        state_reg <= S_TRK_INIT;
                    end
                end
                S_MQ: begin
                    if (k_reg != 6'd0) begin
                        qp_reg[km1[3:0]] <= 48'(prod_reg >>> 16);
                    end
                    if (k_reg == 6'd9) begin
                        k_reg     <= '0;
                        state_reg <= S_MS;
                    end else begin
                        k_reg <= k_reg + 6'd1;
                    end
                end
                S_MS: begin
                    // rotation element, then product with scale, then saturate
                    if (k_reg < 6'd3) begin
                        rot_reg <= sat32(68'(rot_full));
                    end
                    if (k_reg >= 6'd2) begin
                        col_reg[km2[1:0]] <= sat32(prod_reg >>> 16);
                    end
                    if (k_reg == 6'd4) begin
                        state_reg <= S_EMIT;
                    end else begin
                        k_reg <= k_reg + 6'd1;
                    end
                end
                S_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= (row_reg == 2'd2);
                        m_tdata_reg  <= {{(M_TDATA_W-130){1'b0}},
                                         trk_res_reg[TRK_POS][row_reg],
                                         col_reg[2], col_reg[1], col_reg[0], row_reg};
                        if (row_reg == 2'd2) begin
                            state_reg <= S_IDLE;
                        end else begin
                            row_reg   <= row_reg + 2'd1;
                            k_reg     <= '0;
                            state_reg <= S_MS;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------- checks
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < {1'b0, den_reg}))
        else $error("divider remainder not below divisor");

    a_factor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LERP) |-> (f_reg <= 17'(QONE)))
        else $error("interpolation factor above one");

    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SQRT && bit_reg == '0) |-> (r_reg <= 34'd65536))
        else $error("slerp root out of range");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (idx_reg <= lim_reg))
        else $error("key scan past count");

    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tlast_reg) |-> (m_tdata_reg[1:0] == 2'd2))
        else $error("last word is not the third row");

endmodule

@@ bench/kts_checker.sv @@
// ----------------------------------------------------------------------------
// kts_checker: result predictor and comparator for the keyframe sampler
// Watches the config port and both stream channels. Keeps its own copy of the
// key tables, rest pose and registers, computes the three matrix rows that
// each sample word must produce and compares every output word in order.
// ----------------------------------------------------------------------------
module kts_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [kts_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [kts_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [kts_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [kts_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [kts_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int                               errors,
    output int                               pending
);
    import kts_pkg::*;

    localparam longint ONE = 65536;

    typedef struct {
        logic [1:0]  row;
        logic [31:0] col[4];
        logic        last;
    } row_word_t;

    row_word_t  rows_due[$];

    longint     key_tm[3*MAX_KEYS];
    longint     key_val[3*MAX_KEYS][4];
    longint     rest[12];
    longint     duration;
    int         key_cnt[3];
    longint     atan_lut[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                 256, 128, 64, 32, 16, 8, 4, 2};

    assign pending = rows_due.size();

    function automatic longint asr(input longint v, input int n);
        if (v >= 0) return v >>> n;
        return -(((-v) + ((longint'(1) << n) - 1)) >>> n);
    endfunction

    function automatic longint sat(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qm(input longint a, input longint b);
        return asr(a * b, 16);
    endfunction

    function automatic longint root(input longint unsigned v);
        longint unsigned r;
        longint unsigned probe;
        r = 0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > v) probe >>= 2;
        while (probe != 0) begin
            if (v >= r + probe) begin
                v -= r + probe;
                r = (r >> 1) + probe;
            end else begin
                r >>= 1;
            end
            probe >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vec_angle(input longint x, input longint y);
        longint z, nx, ny;
        z = 0;
        for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
                nx = x + asr(y, i); ny = y - asr(x, i); z += atan_lut[i];
            end else begin
                nx = x - asr(y, i); ny = y + asr(x, i); z -= atan_lut[i];
            end
            x = nx; y = ny;
        end
        return z;
    endfunction

    function automatic longint sine(input longint z);
        longint x, y, nx, ny;
        x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - asr(y, i); ny = y + asr(x, i); z -= atan_lut[i];
            end else begin
                nx = x + asr(y, i); ny = y - asr(x, i); z += atan_lut[i];
            end
            x = nx; y = ny;
        end
        return y;
    endfunction

    function automatic longint mix(input longint a, input longint b, input longint f);
        return sat(a + asr((b - a) * f, 16));
    endfunction

    // bracketing keys of one track; returns -1 when the start values stand as is
    function automatic longint bracket(input int tr, input longint t,
                                       output longint a[4], output longint b[4]);
        longint t1, t2, span, f;
        int     cnt, k;
        t1 = 0;
        t2 = duration;
        cnt = (key_cnt[tr] > MAX_KEYS) ? MAX_KEYS : key_cnt[tr];
        for (int j = 0; j < 4; j++) begin
            a[j] = rest[tr*4 + j];
            b[j] = a[j];
        end
        for (int i = cnt - 1; i >= 0; i--) begin
            k = tr*MAX_KEYS + i;
            if (t >= key_tm[k] && key_tm[k] >= t1) begin
                t1 = key_tm[k];
                for (int j = 0; j < 4; j++) a[j] = key_val[k][j];
            end
        end
        for (int i = 0; i < cnt; i++) begin
            k = tr*MAX_KEYS + i;
            if (key_tm[k] > t && key_tm[k] <= t2) begin
                t2 = key_tm[k];
                for (int j = 0; j < 4; j++) b[j] = key_val[k][j];
            end
        end
        span = t2 - t1;
        if (span <= 0) return -1;
        f = ((t - t1) * ONE) / span;
        if (f < 0) f = 0;
        if (f > ONE) f = ONE;
        return f;
    endfunction

    function automatic void quat_slerp(input longint a[4], input longint bi[4],
                                       input longint f, output longint r[4]);
        longint b[4];
        longint d, s, th, w1, w2;
        d = 0;
        for (int j = 0; j < 4; j++) begin
            b[j] = bi[j];
            d += qm(a[j], b[j]);
        end
        if (d < 0) begin
            d = -d;
            for (int j = 0; j < 4; j++) b[j] = -b[j];
        end
        if (d >= ONE) begin
            for (int j = 0; j < 4; j++) r[j] = mix(a[j], b[j], f);
        end else begin
            s = root(longint'(ONE * ONE - d * d));
            th = vec_angle(d, s);
            w1 = sine(asr((ONE - f) * th, 16));
            w2 = sine(asr(f * th, 16));
            for (int j = 0; j < 4; j++) r[j] = sat((w1 * a[j] + w2 * b[j]) / s);
        end
    endfunction

    // pose matrix rows for one sample time
    function automatic void predict_pose(input longint t);
        longint    q[4], p[4], sc[4], a[4], b[4];
        longint    f, w, x, y, z;
        longint    xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint    rot[3][3];
        row_word_t rw;
        if (duration <= 0) begin
            for (int j = 0; j < 4; j++) begin
                q[j] = rest[j]; p[j] = rest[4+j]; sc[j] = rest[8+j];
            end
        end else begin
            f = bracket(0, t, a, b);
            if (f < 0) q = a;
            else quat_slerp(a, b, f, q);
            f = bracket(1, t, a, b);
            for (int j = 0; j < 4; j++) p[j] = (f < 0) ? a[j] : mix(a[j], b[j], f);
            f = bracket(2, t, a, b);
            for (int j = 0; j < 4; j++) sc[j] = (f < 0) ? a[j] : mix(a[j], b[j], f);
        end
        w = q[0]; x = q[1]; y = q[2]; z = q[3];
        xx = qm(x, x); yy = qm(y, y); zz = qm(z, z);
        xy = qm(x, y); xz = qm(x, z); yz = qm(y, z);
        wx = qm(w, x); wy = qm(w, y); wz = qm(w, z);
        rot[0][0] = sat(ONE - 2*(yy + zz));
        rot[0][1] = sat(2*(xy - wz));
        rot[0][2] = sat(2*(xz + wy));
        rot[1][0] = sat(2*(xy + wz));
        rot[1][1] = sat(ONE - 2*(xx + zz));
        rot[1][2] = sat(2*(yz - wx));
        rot[2][0] = sat(2*(xz - wy));
        rot[2][1] = sat(2*(yz + wx));
        rot[2][2] = sat(ONE - 2*(xx + yy));
        for (int r = 0; r < 3; r++) begin
            rw.row = r[1:0];
            for (int c = 0; c < 3; c++) rw.col[c] = sat(qm(rot[r][c], sc[c]));
            rw.col[3] = p[r];
            rw.last = (r == 2);
            rows_due.push_back(rw);
        end
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge aclk) begin
        logic [1:0]  op, trk;
        logic [31:0] tv;
        int          k;
        row_word_t   exp_row;
        if (!aresetn) begin
            rows_due.delete();
            for (int i = 0; i < 12; i++) rest[i] = 0;
            rest[0] = ONE; rest[8] = ONE; rest[9] = ONE; rest[10] = ONE;
            duration = 0;
            key_cnt = '{0, 0, 0};
        end else begin
            if (m_tvalid && m_tready) begin
                if (rows_due.size() == 0) begin
                    report("unexpected word", m_tdata[31:0], 0);
                end else begin
                    exp_row = rows_due.pop_front();
                    if (m_tdata[1:0] != exp_row.row)
                        report("row_index", m_tdata[1:0], exp_row.row);
                    for (int c = 0; c < 4; c++)
                        if (m_tdata[2+32*c +: 32] != exp_row.col[c])
                            report($sformatf("col%0d row %0d", c, exp_row.row),
                                   m_tdata[2+32*c +: 32], exp_row.col[c]);
                    if (m_tlast != exp_row.last)
                        report("last_row", m_tlast, exp_row.last);
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DURATION: duration = longint'($signed(cfg_wdata));
                    REG_ROT_CNT:  key_cnt[0] = cfg_wdata[6:0];
                    REG_POS_CNT:  key_cnt[1] = cfg_wdata[6:0];
                    REG_SCL_CNT:  key_cnt[2] = cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                op  = s_tuser[1:0];
                trk = s_tuser[3:2];
                tv  = s_tdata[37:6];
                if (op == OP_LOAD_KEY && trk != 2'd3) begin
                    k = trk*MAX_KEYS + s_tdata[5:0];
                    key_tm[k] = longint'($signed(tv));
                    for (int j = 0; j < 4; j++)
                        key_val[k][j] = longint'($signed(s_tdata[38+32*j +: 32]));
                end else if (op == OP_LOAD_REST && trk != 2'd3) begin
                    for (int j = 0; j < 4; j++)
                        rest[trk*4 + j] = longint'($signed(s_tdata[38+32*j +: 32]));
                end else if (op == OP_SAMPLE) begin
                    predict_pose(longint'($signed(tv)));
                end
            end
        end
    end

endmodule

@@ bench/tb_keyframe_transform_sampler_top.sv @@
// ----------------------------------------------------------------------------
// tb_keyframe_transform_sampler_top: stimulus for the keyframe sampler
// Loads rest poses and full key tables, then runs phases of sample and load
// words under several clip durations and key counts, with bursty input,
// receiver stalls and one long hold-off. Checking is done by kts_checker.
// ----------------------------------------------------------------------------
module tb_keyframe_transform_sampler_top;
    import kts_pkg::*;

    localparam int IDLE_LIMIT = 12000;
    localparam int HOLD_CYCLES = 1500;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    int                     errors;
    int                     pending;
    int                     burst_left;
    int                     idle_cycles;
    logic                   hold_req;
    longint                 dur_now;

    keyframe_transform_sampler_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    kts_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver: alternating windows of random stalls and full rate, one long hold
    initial begin
        int cyc;
        cyc = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            if ((cyc / 97) % 3 == 0) m_tready = 1'b1;
            else m_tready = ($urandom_range(0, 3) != 0);
        end
    end

    function automatic logic [31:0] any_comp();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            default: return $urandom_range(0, 131072) - 65536;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [1:0] op, input logic [1:0] trk,
                             input logic [5:0] idx, input logic [31:0] tv,
                             input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] d);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, d, c, b, a, tv, idx};
        s_tuser  = {trk, op};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic reg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] v);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic sample_at(input logic [31:0] t);
        send_word(OP_SAMPLE, $urandom_range(0, 3), $urandom, t,
                  $urandom, $urandom, $urandom, $urandom);
    endtask

    // keys sorted in time across the clip, sometimes repeated times
    task automatic fill_track(input logic [1:0] trk, input longint span);
        longint t;
        t = 0;
        for (int i = 0; i < MAX_KEYS; i++) begin
            if (trk == TRK_ROT)
                send_word(OP_LOAD_KEY, trk, i[5:0], t[31:0], any_comp(), any_comp(),
                          any_comp(), any_comp());
            else
                send_word(OP_LOAD_KEY, trk, i[5:0], t[31:0], any_comp(), any_comp(),
                          any_comp(), $urandom);
            if ($urandom_range(0, 7) != 0) t += $urandom_range(1, span / MAX_KEYS);
        end
    endtask

    initial begin
        longint span;
        logic [31:0] durs[6];
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        burst_left = 0;
        hold_req = 1'b0;
        aresetn = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // rest pose after reset, then rest loads incl. extremes
        sample_at(32'h0);
        sample_at(32'h7fff_ffff);
        send_word(OP_LOAD_REST, TRK_ROT, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 32'h8000_0000);
        send_word(OP_LOAD_REST, TRK_SCL, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
        sample_at(32'h8000_0000);
        send_word(OP_LOAD_REST, TRK_ROT, 0, 0, 46341, 0, 46341, 0);
        send_word(OP_LOAD_REST, TRK_POS, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 12345, $urandom);
        send_word(OP_LOAD_REST, TRK_SCL, 0, 0, 65536, 131072, 32768, $urandom);
        sample_at($urandom);
        // ignored words: track three and op three
        send_word(OP_LOAD_REST, 2'd3, 0, 0, $urandom, $urandom, $urandom, $urandom);
        send_word(2'd3, TRK_ROT, 0, 0, $urandom, $urandom, $urandom, $urandom);
        send_word(OP_LOAD_KEY, 2'd3, 6'd63, $urandom, $urandom, $urandom, $urandom, $urandom);
        sample_at(32'h1);
        send_word(OP_LOAD_REST, TRK_ROT, 0, 0, 65536, 0, 0, 0);
        send_word(OP_LOAD_REST, TRK_POS, 0, 0, 65536, 0, -65536, 0);
        send_word(OP_LOAD_REST, TRK_SCL, 0, 0, 65536, 65536, 65536, 0);
        drain();

        span = 64'd4194304;
        fill_track(TRK_ROT, span);
        fill_track(TRK_POS, span);
        fill_track(TRK_SCL, span);
        drain();

        durs = '{32'h0040_0000, 32'h7fff_ffff, 32'h0000_0001, 32'h8000_0000,
                 32'h0020_0000, 32'h0000_0000};
        for (int ph = 0; ph < 8; ph++) begin
            dur_now = (ph < 6) ? longint'($signed(durs[ph])) : $urandom_range(1, 32'h0080_0000);
            reg_write(REG_DURATION, dur_now[31:0]);
            case (ph)
                0: begin
                    reg_write(REG_ROT_CNT, 64); reg_write(REG_POS_CNT, 64);
                    reg_write(REG_SCL_CNT, 64);
                end
                1: begin
                    reg_write(REG_ROT_CNT, 127); reg_write(REG_POS_CNT, 0);
                    reg_write(REG_SCL_CNT, 1);
                end
                2: begin
                    reg_write(REG_ROT_CNT, 0); reg_write(REG_POS_CNT, 127);
                    reg_write(REG_SCL_CNT, 65);
                end
                default: begin
                    reg_write(REG_ROT_CNT, $urandom_range(0, 127));
                    reg_write(REG_POS_CNT, $urandom_range(0, 127));
                    reg_write(REG_SCL_CNT, $urandom_range(0, 127));
                end
            endcase
            if (ph == 3) hold_req = 1'b1;
            for (int n = 0; n < 16; n++) begin
                if ($urandom_range(0, 9) < 7) begin
                    if ($urandom_range(0, 5) == 0) sample_at($urandom);
                    else if (dur_now > 0)
                        sample_at($urandom_range(0, dur_now + 65536) - 32768);
                    else sample_at($urandom_range(0, 32'h0050_0000) - 65536);
                end else if ($urandom_range(0, 7) == 0) begin
                    send_word(OP_LOAD_REST, $urandom_range(0, 2), $urandom, $urandom,
                              any_comp(), any_comp(), any_comp(), any_comp());
                end else begin
                    send_word(OP_LOAD_KEY, $urandom_range(0, 2), $urandom,
                              ($urandom_range(0, 4) == 0) ? $urandom
                                                          : $urandom_range(0, 32'h0040_0000),
                              any_comp(), any_comp(), any_comp(), any_comp());
                end
            end
            drain();
        end

        repeat (200) @(negedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
